// ===== hdl/ptu_pkg.sv =====
// Shared types and constants of the particle table update unit.
// No dependencies.
package ptu_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_STATE   = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_CLEARED = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_WB,
        S_FLUSH
    } state_t;

    // most particle results one tick reports
    localparam int MAX_OUT = 64;

    // one table entry as held in the particle RAM
    typedef struct packed {
        logic [15:0] life;
        logic [15:0] age;
        logic [31:0] pos;     // x high, y low, Q11.4
        logic [31:0] vel;
        logic [31:0] acc;
        logic [31:0] scale;   // begin high, end low
        logic [63:0] color;   // begin high, end low
        logic [7:0]  divisor;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== hdl/particle_table_update_unit.sv =====
// Particle table update unit: top level with control sequencer and datapath.
// Depends on ptu_pkg, ptu_ram and ptu_div.
//
// Keeps up to PARTICLES particles in one RAM, ordered newest first as a ring
// behind a head pointer. A transfer is taken when start is high and busy low;
// add, clear and tick answer through result_valid one cycle per result, and
// the receiver cannot stall it, so the unit never waits on its output. Add,
// clear and the unused command (which gives no result) keep busy low. A tick
// walks the table once: a removed particle passes S_READ and S_LOAD, a
// survivor also S_MUL, S_DIV and S_WB, waiting on the 32-step divider that
// forms the interpolated scale (all seven divisions per particle run side by
// side). S_READ and S_FLUSH end the tick. Survivors are compacted in place as
// the walk goes; results lag one survivor so that last marks the final one.
module particle_table_update_unit
    import ptu_pkg::*;
#(
    parameter int PARTICLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] life_frames,
    input  logic [31:0] start_position,
    input  logic [31:0] start_velocity,
    input  logic [31:0] acceleration,
    input  logic [15:0] scale_begin,
    input  logic [15:0] scale_end,
    input  logic [31:0] color_begin,
    input  logic [31:0] color_end,
    input  logic [7:0]  speed_divisor,
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic [15:0] scale_now,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last
);
    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CW = $clog2(PARTICLES + 1);

    state_t state_reg, state_next;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] k_reg;      // read position of the walk
    logic [CW-1:0] keep_reg;   // survivors so far

    entry_t ent_reg;
    logic signed [15:0] vx_reg, vy_reg;

    // pending tick result, held until the next survivor or the end of the walk
    logic        pend_valid_reg;
    logic [15:0] pend_px_reg, pend_py_reg, pend_sc_reg;
    logic [31:0] pend_col_reg;

    logic        accept;
    logic        full;
    logic [AW-1:0] head_dec;

    // RAM port controls
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;
    logic          div_start;

    assign accept   = start && !busy;
    assign full     = count_reg >= CW'(PARTICLES);
    assign head_dec = (head_reg == '0) ? AW'(PARTICLES - 1) : head_reg - 1'b1;

    // ring position of order index idx
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                           input logic [CW-1:0] idx);
        logic [AW+1:0] s;
        s = (AW+2)'(hd) + (AW+2)'(idx);
        if (s >= (AW+2)'(PARTICLES))
            s = s - (AW+2)'(PARTICLES);
        return s[AW-1:0];
    endfunction

    ptu_ram #(.WIDTH(ENTRY_W), .DEPTH(PARTICLES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- load stage: survival test and velocity update
    logic survive;
    logic signed [16:0] vsum_x, vsum_y;
    assign survive = ram_rdata.age < ram_rdata.life;
    assign vsum_x  = 17'(signed'(ram_rdata.vel[31:16])) + 17'(signed'(ram_rdata.acc[31:16]));
    assign vsum_y  = 17'(signed'(ram_rdata.vel[15:0]))  + 17'(signed'(ram_rdata.acc[15:0]));

    // ---- multiply stage: differences times new age, magnitudes for dividers
    logic [15:0]        age_new;
    logic [7:0]         dv;
    logic signed [16:0] ds;
    logic signed [33:0] prod_s;
    logic [31:0]        mag_s;
    logic [15:0]        mag_vx, mag_vy;
    logic signed [8:0]  dc   [4];
    logic signed [25:0] prod_c [4];
    logic [23:0]        mag_c  [4];
    logic               neg_vx_reg, neg_vy_reg, neg_s_reg;
    logic [3:0]         neg_c_reg;

    assign age_new = ent_reg.age + 16'd1;
    assign dv      = (ent_reg.divisor == 8'd0) ? 8'd1 : ent_reg.divisor;
    assign ds      = signed'({1'b0, ent_reg.scale[15:0]}) - signed'({1'b0, ent_reg.scale[31:16]});
    assign prod_s  = 34'(ds) * 34'(signed'({1'b0, age_new}));
    assign mag_s   = prod_s[33] ? 32'(-prod_s) : prod_s[31:0];
    assign mag_vx  = vx_reg[15] ? 16'(-vx_reg) : 16'(vx_reg);
    assign mag_vy  = vy_reg[15] ? 16'(-vy_reg) : 16'(vy_reg);

    for (genvar c = 0; c < 4; c++)
    begin : g_cmul
        localparam int SH = 24 - 8 * c;
        assign dc[c]     = signed'({1'b0, ent_reg.color[SH +: 8]})
                         - signed'({1'b0, ent_reg.color[32 + SH +: 8]});
        assign prod_c[c] = 26'(dc[c]) * 26'(signed'({1'b0, age_new}));
        assign mag_c[c]  = prod_c[c][25] ? 24'(-prod_c[c]) : prod_c[c][23:0];
    end

    // ---- divider lanes
    logic [15:0] q_vx, q_vy;
    logic [31:0] q_s;
    logic [23:0] q_c [4];
    logic        d_vx, d_vy, d_s;
    logic [3:0]  d_c;

    ptu_div #(.DW(16), .VW(8)) u_div_vx (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_vx),
        .divisor(dv), .quotient(q_vx), .done(d_vx));
    ptu_div #(.DW(16), .VW(8)) u_div_vy (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_vy),
        .divisor(dv), .quotient(q_vy), .done(d_vy));
    ptu_div #(.DW(32), .VW(16)) u_div_s (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_s),
        .divisor(ent_reg.life), .quotient(q_s), .done(d_s));

    for (genvar c = 0; c < 4; c++)
    begin : g_cdiv
        ptu_div #(.DW(24), .VW(16)) u_div_c (
            .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_c[c]),
            .divisor(ent_reg.life), .quotient(q_c[c]), .done(d_c[c]));
    end

    logic all_done;
    assign all_done = d_vx && d_vy && d_s && (d_c == 4'hf);

    // ---- write-back stage: sign restore, position and interpolation
    logic signed [16:0] sq_x, sq_y;
    logic signed [15:0] px_new, py_new;
    logic signed [32:0] sq_s;
    logic [32:0]        sc_sum;
    logic [15:0]        sc_new;
    logic [31:0]        col_new;
    entry_t             ent_wb;

    assign sq_x   = neg_vx_reg ? -signed'({1'b0, q_vx}) : signed'({1'b0, q_vx});
    assign sq_y   = neg_vy_reg ? -signed'({1'b0, q_vy}) : signed'({1'b0, q_vy});
    assign px_new = sat16(18'(signed'(ent_reg.pos[31:16])) + 18'(sq_x));
    assign py_new = sat16(18'(signed'(ent_reg.pos[15:0]))  + 18'(sq_y));
    assign sq_s   = neg_s_reg ? -signed'({1'b0, q_s}) : signed'({1'b0, q_s});
    assign sc_sum = 33'({1'b0, ent_reg.scale[31:16]}) + 33'(sq_s);
    assign sc_new = sc_sum[15:0];

    for (genvar c = 0; c < 4; c++)
    begin : g_cwb
        localparam int SH = 24 - 8 * c;
        logic signed [24:0] sq;
        logic [24:0]        sum;
        assign sq  = neg_c_reg[c] ? -signed'({1'b0, q_c[c]}) : signed'({1'b0, q_c[c]});
        assign sum = 25'({1'b0, ent_reg.color[32 + SH +: 8]}) + 25'(sq);
        assign col_new[SH +: 8] = sum[7:0];
    end

    always_comb
    begin
        ent_wb     = ent_reg;
        ent_wb.age = age_new;
        ent_wb.vel = {vx_reg, vy_reg};
        ent_wb.pos = {px_new, py_new};
    end

    // ---- sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_t'(cmd) == CMD_TICK)
                    state_next = S_READ;
            end
            S_READ:  state_next = (k_reg == count_reg) ? S_FLUSH : S_LOAD;
            S_LOAD:  state_next = survive ? S_MUL : S_READ;
            S_MUL:   state_next = S_DIV;
            S_DIV:   state_next = all_done ? S_WB : S_DIV;
            S_WB:    state_next = S_READ;
            S_FLUSH: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---- sequencer: RAM and divider controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = head_dec;
        ram_wdata = ent_wb;
        ram_re    = 1'b0;
        ram_raddr = phys(head_reg, k_reg);
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_t'(cmd) == CMD_ADD && !full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = head_dec;
                    ram_wdata = '{life: life_frames, age: 16'd0, pos: start_position,
                                  vel: start_velocity, acc: acceleration,
                                  scale: {scale_begin, scale_end},
                                  color: {color_begin, color_end},
                                  divisor: speed_divisor};
                end
            end
            S_READ:  ram_re = (k_reg != count_reg);
            S_MUL:   div_start = 1'b1;
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, keep_reg);
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            keep_reg       <= '0;
            pend_valid_reg <= 1'b0;
            result_valid   <= 1'b0;
            kind           <= KIND_STATE;
            last           <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_t'(cmd))
                            CMD_ADD:
                            begin
                                result_valid <= 1'b1;
                                last         <= 1'b1;
                                if (full)
                                    kind <= KIND_FULL;
                                else
                                begin
                                    kind      <= KIND_ADDED;
                                    head_reg  <= head_dec;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_TICK:
                            begin
                                k_reg          <= '0;
                                keep_reg       <= '0;
                                pend_valid_reg <= 1'b0;
                            end
                            CMD_CLEAR:
                            begin
                                count_reg    <= '0;
                                result_valid <= 1'b1;
                                kind         <= KIND_CLEARED;
                                last         <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (!survive)
                        k_reg <= k_reg + 1'b1;
                end
                S_WB:
                begin
                    k_reg    <= k_reg + 1'b1;
                    keep_reg <= keep_reg + 1'b1;
                    if (32'(keep_reg) < MAX_OUT)
                    begin
                        pend_valid_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            result_valid <= 1'b1;
                            kind         <= KIND_STATE;
                            last         <= 1'b0;
                        end
                    end
                end
                S_FLUSH:
                begin
                    count_reg    <= keep_reg;
                    result_valid <= 1'b1;
                    last         <= 1'b1;
                    kind         <= pend_valid_reg ? KIND_STATE : KIND_EMPTY;
                end
                default: ;
            endcase
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pos_x     <= '0;
                pos_y     <= '0;
                scale_now <= '0;
                {red, green, blue, alpha} <= '0;
            end
            S_LOAD:
            begin
                ent_reg <= ram_rdata;
                vx_reg  <= sat16(18'(vsum_x));
                vy_reg  <= sat16(18'(vsum_y));
            end
            S_MUL:
            begin
                neg_vx_reg <= vx_reg[15];
                neg_vy_reg <= vy_reg[15];
                neg_s_reg  <= prod_s[33];
                for (int c = 0; c < 4; c++)
                begin
                    neg_c_reg[c] <= prod_c[c][25];
                end
            end
            S_WB:
            begin
                if (32'(keep_reg) < MAX_OUT)
                begin
                    pos_x        <= pend_px_reg;
                    pos_y        <= pend_py_reg;
                    scale_now    <= pend_sc_reg;
                    {red, green, blue, alpha} <= pend_col_reg;
                    pend_px_reg  <= px_new;
                    pend_py_reg  <= py_new;
                    pend_sc_reg  <= sc_new;
                    pend_col_reg <= col_new;
                end
            end
            S_FLUSH:
            begin
                pos_x     <= pend_valid_reg ? pend_px_reg : '0;
                pos_y     <= pend_valid_reg ? pend_py_reg : '0;
                scale_now <= pend_valid_reg ? pend_sc_reg : '0;
                {red, green, blue, alpha} <= pend_valid_reg ? pend_col_reg : '0;
            end
            default: ;
        endcase
    end

    // ---- checks
    a_ctl_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_STATE |-> last)
        else $error("non-particle result without last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= PARTICLES)
        else $error("live count beyond table size");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |=> result_valid && last && state_reg == S_IDLE)
        else $error("tick did not end with a final result");

    a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd_t'(cmd) == CMD_ADD |=> result_valid && last && !busy)
        else $error("add not answered in one cycle");

    a_keep_le_k: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> keep_reg <= k_reg)
        else $error("compaction overtook the read position");
endmodule

// ===== hdl/ptu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/ptu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module ptu_div #(
    parameter int DW = 16,
    parameter int VW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   quo_reg;
    logic [VW:0]     rem_reg;
    logic [VW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;
    logic            take;

    assign rem_sh  = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign take    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNTW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= take ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[DW-2:0], take};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for particle_table_update_unit: command driver, result
// monitor and an in-bench particle table predictor. Depends on ptu_pkg and the RTL.
module tb_top;
    import ptu_pkg::*;

    localparam int NSLOT      = 64;
    localparam int IDLE_LIMIT = 20000;   // covers a full tick of NSLOT particles between transfers
    localparam int TAIL_WAIT  = 100;

    typedef struct {
        cmd_t        op;
        logic [15:0] life;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [15:0] sc_b;
        logic [15:0] sc_e;
        logic [31:0] col_b;
        logic [31:0] col_e;
        logic [7:0]  div;
        bit          drain;     // wait for the table to go quiet before this transfer
    } cmd_item_t;

    typedef struct {
        kind_t       knd;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] sc;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        lst;
    } particle_out_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        result_valid;
    logic [2:0]  kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0] scale_now;
    logic [7:0]  red, green, blue, alpha;
    logic        last;
    cmd_item_t   drv;

    particle_table_update_unit #(.PARTICLES(NSLOT)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (drv.op),
        .life_frames    (drv.life),
        .start_position (drv.pos),
        .start_velocity (drv.vel),
        .acceleration   (drv.acc),
        .scale_begin    (drv.sc_b),
        .scale_end      (drv.sc_e),
        .color_begin    (drv.col_b),
        .color_end      (drv.col_e),
        .speed_divisor  (drv.div),
        .result_valid   (result_valid),
        .kind           (kind),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .scale_now      (scale_now),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .last           (last)
    );

    // clock and the single reset pulse
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Shadow particle table; mirrors the slot order, newest first.
    // ---------------------------------------------------------------
    int            live_cnt;
    int            slot_order [NSLOT];
    logic [15:0]   p_life  [NSLOT];
    logic [15:0]   p_age   [NSLOT];
    logic [31:0]   p_pos   [NSLOT];
    logic [31:0]   p_vel   [NSLOT];
    logic [31:0]   p_acc   [NSLOT];
    logic [31:0]   p_scale [NSLOT];
    logic [63:0]   p_color [NSLOT];
    logic [7:0]    p_div   [NSLOT];

    cmd_item_t     pending_cmds [$];
    particle_out_t expected_outs [$];
    int            mismatches;
    bit            failed;

    initial
    begin
        live_cnt = 0;
        for (int i = 0; i < NSLOT; i++)
            slot_order[i] = i;
        mismatches = 0;
        failed = 0;
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // start + (end - start) * age / life, truncating toward zero
    function automatic longint blend(longint s, longint e, longint ag, longint lf);
        return s + ((e - s) * ag) / lf;
    endfunction

    function automatic particle_out_t status_out(kind_t k);
        particle_out_t o;
        o = '{knd: k, px: '0, py: '0, sc: '0, r: '0, g: '0, b: '0, a: '0, lst: 1'b1};
        return o;
    endfunction

    task automatic step_table(input cmd_item_t it);
        int            id, keep, nrem, vx, vy, px, py, dv;
        int            gone [NSLOT];
        particle_out_t o;
        logic [7:0]    ch [4];
        begin
            case (it.op)
                CMD_ADD:
                begin
                    if (live_cnt >= NSLOT)
                        expected_outs.push_back(status_out(KIND_FULL));
                    else
                    begin
                        id = slot_order[live_cnt];
                        for (int k = live_cnt; k > 0; k--)
                            slot_order[k] = slot_order[k-1];
                        slot_order[0] = id;
                        p_life[id]  = it.life;
                        p_age[id]   = '0;
                        p_pos[id]   = it.pos;
                        p_vel[id]   = it.vel;
                        p_acc[id]   = it.acc;
                        p_scale[id] = {it.sc_b, it.sc_e};
                        p_color[id] = {it.col_b, it.col_e};
                        p_div[id]   = it.div;
                        live_cnt++;
                        expected_outs.push_back(status_out(KIND_ADDED));
                    end
                end
                CMD_TICK:
                begin
                    // retire expired particles, keep survivor order
                    keep = 0;
                    nrem = 0;
                    for (int k = 0; k < live_cnt; k++)
                    begin
                        id = slot_order[k];
                        if (p_age[id] < p_life[id])
                        begin
                            slot_order[keep] = id;
                            keep = keep + 1;
                        end
                        else
                        begin
                            gone[nrem] = id;
                            nrem = nrem + 1;
                        end
                    end
                    for (int k = 0; k < nrem; k++)
                        slot_order[keep + k] = gone[k];
                    live_cnt = keep;
                    if (keep == 0)
                        expected_outs.push_back(status_out(KIND_EMPTY));
                    for (int k = 0; k < keep; k++)
                    begin
                        id = slot_order[k];
                        p_age[id] = p_age[id] + 16'd1;
                        vx = clamp16($signed(p_vel[id][31:16]) + $signed(p_acc[id][31:16]));
                        vy = clamp16($signed(p_vel[id][15:0]) + $signed(p_acc[id][15:0]));
                        p_vel[id] = {vx[15:0], vy[15:0]};
                        dv = (p_div[id] == 0) ? 1 : int'(p_div[id]);
                        px = clamp16($signed(p_pos[id][31:16]) + vx / dv);
                        py = clamp16($signed(p_pos[id][15:0]) + vy / dv);
                        p_pos[id] = {px[15:0], py[15:0]};
                        for (int c = 0; c < 4; c++)
                            ch[c] = 8'(blend(p_color[id][63-8*c -: 8], p_color[id][31-8*c -: 8],
                                             p_age[id], p_life[id]));
                        o.knd = KIND_STATE;
                        o.px  = px[15:0];
                        o.py  = py[15:0];
                        o.sc  = 16'(blend(p_scale[id][31:16], p_scale[id][15:0],
                                          p_age[id], p_life[id]));
                        o.r   = ch[0];
                        o.g   = ch[1];
                        o.b   = ch[2];
                        o.a   = ch[3];
                        o.lst = (k + 1 == keep) && (k < MAX_OUT);
                        if (k < MAX_OUT)
                        begin
                            if (k + 1 == MAX_OUT)
                                o.lst = 1'b1;
                            expected_outs.push_back(o);
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    live_cnt = 0;
                    expected_outs.push_back(status_out(KIND_CLEARED));
                end
                default: ;   // unused command: no effect, no result
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic logic [15:0] edgy16();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h7fff;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] small_q(int mag);
        return 16'($signed($urandom_range(0, 2 * mag)) - mag);
    endfunction

    function automatic cmd_item_t make_add();
        cmd_item_t it;
        int sel;
        it.op    = CMD_ADD;
        it.drain = 0;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            it.life = 16'($urandom_range(1, 12));
        else if (sel < 16)
            it.life = 16'd0;
        else if (sel < 17)
            it.life = 16'hffff;
        else
            it.life = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            it.pos = {edgy16(), edgy16()};
            it.vel = {edgy16(), edgy16()};
            it.acc = {edgy16(), edgy16()};
        end
        else
        begin
            it.pos = $urandom;
            it.vel = {small_q(2000), small_q(2000)};
            it.acc = {small_q(300), small_q(300)};
        end
        it.sc_b  = edgy16();
        it.sc_e  = edgy16();
        it.col_b = $urandom;
        it.col_e = $urandom;
        it.div   = ($urandom_range(0, 4) == 0) ? 8'(($urandom_range(0, 1)) * 255)
                                               : 8'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t make_cmd(cmd_t op);
        cmd_item_t it;
        it = make_add();   // payload stays random on non-add commands
        it.op = op;
        return it;
    endfunction

    // gap after a transfer: mostly none or short, a few long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        cmd_item_t it;
        int n, sel;
        // directed part
        pending_cmds.push_back(make_cmd(CMD_TICK));              // empty table tick
        pending_cmds.push_back(make_cmd(CMD_CLEAR));
        pending_cmds.push_back(make_cmd(CMD_NONE));              // unused command
        it = make_add();
        it.life = 16'd0;                                         // removed silently
        pending_cmds.push_back(it);
        it = make_add();
        it.life = 16'd1;
        it.div  = 8'd0;                                          // divisor of zero
        pending_cmds.push_back(it);
        it = make_add();
        it.life = 16'hffff;
        it.pos  = 32'h7fff_8000;
        it.vel  = 32'h7fff_8000;                                 // velocity saturates
        it.acc  = 32'h7fff_8000;
        it.div  = 8'd1;
        it.sc_b = 16'h0000;
        it.sc_e = 16'hffff;
        it.col_b = 32'h00ff_00ff;
        it.col_e = 32'hff00_ff00;
        pending_cmds.push_back(it);
        it = make_add();
        it.life = 16'd3;
        it.pos  = 32'h7ff0_8010;
        it.vel  = 32'h0100_ff00;                                 // position near both limits
        it.acc  = 32'h0000_0000;
        it.div  = 8'd255;
        pending_cmds.push_back(it);
        it = make_add();
        it.life = 16'd5;
        it.vel  = 32'hffed_0013;                                 // negative truncation
        it.div  = 8'd7;
        pending_cmds.push_back(it);
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(CMD_TICK));
        it = make_cmd(CMD_NONE);
        it.drain = 1;
        pending_cmds.push_back(it);
        pending_cmds.push_back(make_cmd(CMD_CLEAR));
        pending_cmds.push_back(make_cmd(CMD_TICK));
        n = pending_cmds.size();

        // random part, with one fill past capacity
        while (n < 480)
        begin
            if (n == 200)
            begin
                pending_cmds.push_back(make_cmd(CMD_CLEAR));
                for (int i = 0; i < NSLOT + 3; i++)
                begin
                    it = make_add();
                    it.life = 16'($urandom_range(2, 40));
                    pending_cmds.push_back(it);
                end
                pending_cmds.push_back(make_cmd(CMD_TICK));
                pending_cmds.push_back(make_cmd(CMD_TICK));
                n += NSLOT + 6;
                continue;
            end
            sel = $urandom_range(0, 99);
            if (sel < 58)
                it = make_add();
            else if (sel < 93)
                it = make_cmd(CMD_TICK);
            else if (sel < 97)
                it = make_cmd(CMD_CLEAR);
            else
                it = make_cmd(CMD_NONE);
            it.drain = ($urandom_range(0, 59) == 0);
            pending_cmds.push_back(it);
            n++;
        end
    end

    // ---------------------------------------------------------------
    // Driver: a transfer happens at an edge with start high, busy low
    // ---------------------------------------------------------------
    int gap_left;
    bit xfer_seen;

    always @(posedge clk or negedge rst_n)
    begin
        bit take;
        if (!rst_n)
        begin
            start    <= 1'b0;
            drv      <= '{op: CMD_NONE, life: '0, pos: '0, vel: '0, acc: '0, sc_b: '0,
                          sc_e: '0, col_b: '0, col_e: '0, div: '0, drain: 0};
            gap_left <= 0;
            xfer_seen <= 0;
        end
        else
        begin
            take = start && !busy;
            xfer_seen <= take;
            if (take)
                step_table(drv);
            if (start && !take)
                ;   // hold the command until busy drops
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && (expected_outs.size() != 0 || busy)))
            begin
                drv <= pending_cmds.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed result is matched against the oldest one due
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        particle_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_outs.size() == 0)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d last=%0b", kind, last);
            end
            else
            begin
                want = expected_outs.pop_front();
                if (kind !== want.knd || pos_x !== want.px || pos_y !== want.py ||
                    scale_now !== want.sc || red !== want.r || green !== want.g ||
                    blue !== want.b || alpha !== want.a || last !== want.lst)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: kind=%0d x=%h y=%h sc=%h rgba=%h%h%h%h last=%0b",
                                 want.knd, want.px, want.py, want.sc,
                                 want.r, want.g, want.b, want.a, want.lst);
                        $display("         got: kind=%0d x=%h y=%h sc=%h rgba=%h%h%h%h last=%0b",
                                 kind, pos_x, pos_y, scale_now, red, green, blue, alpha, last);
                    end
                end
            end
        end
    end

    // watchdog: cycles with neither a transfer nor a result
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || xfer_seen || result_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        wait (pending_cmds.size() == 0 && !start && expected_outs.size() == 0 && !busy);
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_outs.size() != 0)
            failed = 1;
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ptu_pkg.sv
hdl/ptu_ram.sv
hdl/ptu_div.sv
hdl/particle_table_update_unit.sv
tb/tb_top.sv
